// ===== design/bounded_array_list_engine_defines.svh =====
// Assertion helpers shared by the list engine RTL.
`ifndef BOUNDED_ARRAY_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BALE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BALE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bale_pkg.sv =====
`default_nettype none

package bale_pkg;

    localparam int DEPTH_DEFAULT = 256;

    localparam int MODE_W     = 3;
    localparam int POSITION_W = 9;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int FOUND_W    = 8;
    localparam int TOTAL_W    = 40;
    localparam int COUNT_W    = 9;
    localparam int CAPACITY_W = 9;

    localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 9'd256;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic signed [TOTAL_W-1:0] total_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_DELETE = 3'd2,
        MODE_SEARCH = 3'd3,
        MODE_SUM    = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    // What every cell does this cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } fsm_t;

endpackage

`default_nettype wire

// ===== design/bale_cell.sv =====
`default_nettype none

module bale_cell
    import bale_pkg::*;
#(
    parameter int IDXW = 8,
    parameter int IDX  = 0
) (
    input  wire logic            aclk,
    input  wire cell_op_t        op,
    input  wire logic [IDXW-1:0] mark,
    input  wire value_t          din,
    input  wire value_t          left,
    input  wire value_t          right,
    input  wire value_t          head,
    output value_t               q
);

    localparam logic [IDXW-1:0] MY_IDX = IDXW'(IDX);

    value_t q_reg;
    value_t q_next;

    always_comb begin
        q_next = q_reg;
        case (op)
            CELL_SHIFT_UP: begin
                if (MY_IDX > mark) begin
                    q_next = left;
                end else if (MY_IDX == mark) begin
                    q_next = din;
                end
            end
            CELL_SHIFT_DOWN: begin
                if (MY_IDX >= mark) begin
                    q_next = right;
                end
            end
            CELL_ROTATE: begin
                // mark is the last held slot; it closes the ring with the head
                q_next = (MY_IDX == mark) ? head : right;
            end
            default: begin
                q_next = q_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// ===== design/bale_row.sv =====
`default_nettype none

module bale_row
    import bale_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                     aclk,
    input  wire cell_op_t                 op,
    input  wire logic [$clog2(DEPTH)-1:0] mark,
    input  wire value_t                   din,
    output value_t                        head
);

    localparam int IDXW = $clog2(DEPTH);

    value_t cell_q [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        value_t left_w;
        value_t right_w;

        if (i == 0) begin : g_first
            assign left_w = cell_q[i];
        end else begin : g_mid_l
            assign left_w = cell_q[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_w = cell_q[i];
        end else begin : g_mid_r
            assign right_w = cell_q[i+1];
        end

        bale_cell #(
            .IDXW (IDXW),
            .IDX  (i)
        ) u_cell (
            .aclk  (aclk),
            .op    (op),
            .mark  (mark),
            .din   (din),
            .left  (left_w),
            .right (right_w),
            .head  (cell_q[0]),
            .q     (cell_q[i])
        );
    end

    assign head = cell_q[0];

endmodule

`default_nettype wire

// ===== design/bounded_array_list_engine.sv =====
// Flow: append, insert, delete and unused modes go from idle to finish after accept;
//   search and sum pass through walk first when entries are held. Finish registers the
//   result once the output is free. Throughput: one item at a time; a new item is taken
//   only in idle (s_ready). Search and sum rotate the cell chain once, one entry per cycle.
// Reset (aresetn low, synchronous): list empty, capacity 256, no result pending.
//   Cell contents are not cleared and are read only after being written.
`default_nettype none

`include "bounded_array_list_engine_defines.svh"

module bounded_array_list_engine
    import bale_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,

    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [CAPACITY_W-1:0]        cfg_wdata,

    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [MODE_W-1:0]            s_mode,
    input  wire logic [POSITION_W-1:0]        s_position,
    input  wire logic signed [VALUE_W-1:0]    s_value,

    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [STATUS_W-1:0]               m_status,
    output logic [FOUND_W-1:0]                m_found_position,
    output logic signed [TOTAL_W-1:0]         m_total,
    output logic [COUNT_W-1:0]                m_count
);

    localparam int IDXW = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int WW   = (CW > POSITION_W) ? CW : POSITION_W;

    fsm_t                    state_reg, state_next;
    logic [CW-1:0]           held_reg;
    logic [CAPACITY_W-1:0]   cap_reg;
    logic                    m_valid_reg;

    mode_t                   req_mode_reg;
    logic [POSITION_W-1:0]   req_pos_reg;
    value_t                  req_value_reg;
    logic [CW-1:0]           walk_reg;
    total_t                  acc_reg;
    logic                    hit_reg;
    logic [CW-1:0]           hit_pos_reg;

    status_t                 m_status_reg;
    logic [FOUND_W-1:0]      m_found_reg;
    total_t                  m_total_reg;
    logic [COUNT_W-1:0]      m_count_reg;

    logic                    accept;
    logic                    out_free;
    logic                    full;
    logic [WW-1:0]           held_w;
    logic [WW-1:0]           pos_w;
    logic [WW-1:0]           cap_w;
    logic [WW-1:0]           hit_pos_w;
    logic [WW-1:0]           fin_held_w;
    logic [CW-1:0]           held_m1;
    mode_t                   s_mode_w;

    status_t                 fin_status;
    cell_op_t                fin_op;
    logic [IDXW-1:0]         fin_mark;
    logic [CW-1:0]           fin_held;
    logic [FOUND_W-1:0]      fin_found;
    total_t                  fin_total;

    cell_op_t                row_op;
    logic [IDXW-1:0]         row_mark;
    value_t                  head;

    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign held_w     = WW'(held_reg);
    assign pos_w      = WW'(req_pos_reg);
    assign cap_w      = WW'(cap_reg);
    assign hit_pos_w  = WW'(hit_pos_reg);
    assign fin_held_w = WW'(fin_held);
    assign held_m1    = held_reg - CW'(1);
    assign s_mode_w   = mode_t'(s_mode);
    assign full       = (held_w >= cap_w) || (held_w >= WW'(DEPTH));

    // Result of the pending request, applied in the finish cycle.
    always_comb begin
        fin_status = ST_DONE;
        fin_op     = CELL_HOLD;
        fin_mark   = held_reg[IDXW-1:0];
        fin_held   = held_reg;
        fin_found  = '0;
        fin_total  = '0;
        case (req_mode_reg)
            MODE_APPEND: begin
                if (full) begin
                    fin_status = ST_FULL;
                end else begin
                    fin_op   = CELL_SHIFT_UP;
                    fin_held = held_reg + CW'(1);
                end
            end
            MODE_INSERT: begin
                if (pos_w > held_w) begin
                    fin_status = ST_RANGE;
                end else if (full) begin
                    fin_status = ST_FULL;
                end else begin
                    fin_op   = CELL_SHIFT_UP;
                    fin_mark = pos_w[IDXW-1:0];
                    fin_held = held_reg + CW'(1);
                end
            end
            MODE_DELETE: begin
                if (pos_w >= held_w) begin
                    fin_status = ST_RANGE;
                end else begin
                    fin_op   = CELL_SHIFT_DOWN;
                    fin_mark = pos_w[IDXW-1:0];
                    fin_held = held_m1;
                end
            end
            MODE_SEARCH: begin
                if (hit_reg) begin
                    fin_found = hit_pos_w[FOUND_W-1:0];
                end else begin
                    fin_status = ST_MISS;
                end
            end
            MODE_SUM: begin
                fin_total = acc_reg;
            end
            default: begin
                fin_status = ST_DONE;
            end
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if ((s_mode_w == MODE_SEARCH || s_mode_w == MODE_SUM) &&
                        held_reg != '0) begin
                        state_next = S_WALK;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_WALK: begin
                if (walk_reg == held_m1) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        s_ready  = 1'b0;
        row_op   = CELL_HOLD;
        row_mark = fin_mark;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_WALK: begin
                row_op   = CELL_ROTATE;
                row_mark = held_m1[IDXW-1:0];
            end
            S_FINISH: begin
                if (out_free) begin
                    row_op = fin_op;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    bale_row #(
        .DEPTH (DEPTH)
    ) u_row (
        .aclk (aclk),
        .op   (row_op),
        .mark (row_mark),
        .din  (req_value_reg),
        .head (head)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            held_reg    <= '0;
            cap_reg     <= CAPACITY_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_wdata;
            end
            if (state_reg == S_FINISH && out_free) begin
                held_reg    <= fin_held;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_mode_reg  <= s_mode_w;
            req_pos_reg   <= s_position;
            req_value_reg <= s_value;
            walk_reg      <= '0;
            acc_reg       <= '0;
            hit_reg       <= 1'b0;
            hit_pos_reg   <= '0;
        end else if (state_reg == S_WALK) begin
            // head is entry walk_reg of the list while the ring turns
            walk_reg <= walk_reg + CW'(1);
            acc_reg  <= acc_reg + {{(TOTAL_W-VALUE_W){head[VALUE_W-1]}}, head};
            if (!hit_reg && head == req_value_reg) begin
                hit_reg     <= 1'b1;
                hit_pos_reg <= walk_reg;
            end
        end
        if (state_reg == S_FINISH && out_free) begin
            m_status_reg <= fin_status;
            m_found_reg  <= fin_found;
            m_total_reg  <= fin_total;
            m_count_reg  <= fin_held_w[COUNT_W-1:0];
        end
    end

    assign cfg_ready        = 1'b1;
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_found_position = m_found_reg;
    assign m_total          = m_total_reg;
    assign m_count          = m_count_reg;

    `BALE_ASSERT_NOW(a_held_bound, aclk, aresetn, 1'b1, held_reg <= CW'(DEPTH),
        "held count above depth")
    `BALE_ASSERT_NOW(a_walk_bound, aclk, aresetn, state_reg == S_WALK, walk_reg < held_reg,
        "walk past last held entry")
    `BALE_ASSERT_NEXT(a_held_stable, aclk, aresetn, state_reg != S_FINISH, $stable(held_reg),
        "held count changed outside finish")
    `BALE_ASSERT_NEXT(a_accept_busy, aclk, aresetn, accept, state_reg != S_IDLE,
        "accepted item did not leave idle")

endmodule

`default_nettype wire
